@@ design/bres_pkg.sv @@
// Shared constants and types for the Bresenham line pixel generator.
package bres_pkg;

	localparam int CFG_W       = 12;
	localparam int ADDR_W      = 22;
	localparam int IDX_W       = 1;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [IDX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
	localparam logic [IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

	localparam logic [CFG_W-1:0] SCREEN_RESET = 12'd700;

	// Classification of one queued word.
	typedef struct packed {
		logic load;
		logic y_major;
		logic minor_inc;
		logic last;
	} bres_ctl_t;

endpackage

@@ design/bres_cmd_if.sv @@
// Command and pixel channel interfaces of the line generator.
interface bres_cmd_if #(parameter int COORD_BITS = 12);
	logic                         valid;
	logic                         ready;
	logic                         kind;
	logic signed [COORD_BITS-1:0] x_begin;
	logic signed [COORD_BITS-1:0] y_begin;
	logic signed [COORD_BITS-1:0] x_end;
	logic signed [COORD_BITS-1:0] y_end;

	modport source (output valid, kind, x_begin, y_begin, x_end, y_end, input ready);
	modport sink (input valid, kind, x_begin, y_begin, x_end, y_end, output ready);
endinterface

interface bres_pix_if #(parameter int COORD_BITS = 12);
	import bres_pkg::*;
	logic                         valid;
	logic                         ready;
	logic                         pixel_valid;
	logic signed [COORD_BITS-1:0] pixel_x;
	logic signed [COORD_BITS-1:0] pixel_y;
	logic                         on_screen;
	logic [ADDR_W-1:0]            pixel_addr;
	logic                         last_pixel;

	modport source (output valid, pixel_valid, pixel_x, pixel_y, on_screen, pixel_addr,
		last_pixel, input ready);
	modport sink (input valid, pixel_valid, pixel_x, pixel_y, on_screen, pixel_addr,
		last_pixel, output ready);
endinterface

@@ design/bresenham_line_pixel_generator_core.sv @@
// Top level of the Bresenham line pixel generator.
//
//   channel  dir  handshake        payload
//   cmd      in   valid / ready    kind, x_begin, y_begin, x_end, y_end
//   pixel    out  valid / ready    pixel_valid, pixel_x, pixel_y, on_screen,
//                                  pixel_addr, last_pixel
//   cfg      in   cfg_wr_en        cfg_index, cfg_data
//
// One word in and one pixel out per clock while the pixel side is ready; an accepted word
// passes from the queue through the stepping stage, the clip stage, the row-times-width
// multiplier and the address add, each of which registers it in turn.
// A four-word queue lets the command side run ahead while the pixel side stalls.
// Reset empties the queue and pipeline, drops any active line and sets both
// screen dimensions to 700.
module bresenham_line_pixel_generator_core #(
	parameter int COORD_BITS = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [bres_pkg::IDX_W-1:0] cfg_index,
	input  logic [bres_pkg::CFG_W-1:0] cfg_data,
	bres_cmd_if.sink                   cmd,
	bres_pix_if.source                 pixel
);
	import bres_pkg::*;

	localparam int ERR_W = COORD_BITS + 3;
	localparam int Q_W   = $bits(bres_ctl_t) + 5*COORD_BITS + ERR_W;

	logic [CFG_W-1:0] screen_width_q, screen_height_q;

	bres_ctl_t                    f_ctl, b_ctl;
	logic signed [COORD_BITS-1:0] f_x_start, f_y_start, f_major_end;
	logic signed [COORD_BITS-1:0] b_x_start, b_y_start, b_major_end;
	logic signed [ERR_W-1:0]      f_err, b_err;
	logic [COORD_BITS-1:0]        f_adx, f_ady, b_adx, b_ady;
	logic                         q_push, q_pop, q_full, q_empty;
	logic [Q_W-1:0]               q_wdata, q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= SCREEN_RESET;
			screen_height_q <= SCREEN_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data;
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	bres_front #(.COORD_BITS(COORD_BITS)) u_front (
		.cmd       (cmd),
		.q_full    (q_full),
		.q_push    (q_push),
		.ctl       (f_ctl),
		.x_start   (f_x_start),
		.y_start   (f_y_start),
		.major_end (f_major_end),
		.err_init  (f_err),
		.abs_dx    (f_adx),
		.abs_dy    (f_ady)
	);

	assign q_wdata = {f_ctl, f_x_start, f_y_start, f_major_end, f_err, f_adx, f_ady};

	bres_fifo #(.WIDTH(Q_W)) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.full  (q_full),
		.pop   (q_pop),
		.rdata (q_rdata),
		.empty (q_empty)
	);

	assign {b_ctl, b_x_start, b_y_start, b_major_end, b_err, b_adx, b_ady} = q_rdata;

	bres_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.screen_width (screen_width_q),
		.screen_height(screen_height_q),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.ctl          (b_ctl),
		.x_start      (b_x_start),
		.y_start      (b_y_start),
		.major_end    (b_major_end),
		.err_init     (b_err),
		.abs_dx       (b_adx),
		.abs_dy       (b_ady),
		.pixel        (pixel)
	);

	// a word with no pixel carries nothing else
	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		pixel.valid && !pixel.pixel_valid |->
		!pixel.on_screen && !pixel.last_pixel && (pixel.pixel_addr == '0))
		else $error("empty pixel word carries data");

	a_off_addr: assert property (@(posedge clk) disable iff (!arst_n)
		pixel.valid && !pixel.on_screen |-> pixel.pixel_addr == '0)
		else $error("off-screen pixel has nonzero address");

	// the queue only fills up right after the back end has held its output
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.ready |-> $past(pixel.valid && !pixel.ready))
		else $error("queue full while back end is free");

endmodule

@@ design/bres_front.sv @@
// Front end: accepts command words and decodes line loads for the queue.
module bres_front #(
	parameter int COORD_BITS = 12
) (
	bres_cmd_if.sink                     cmd,
	input  logic                         q_full,
	output logic                         q_push,
	output bres_pkg::bres_ctl_t          ctl,
	output logic signed [COORD_BITS-1:0] x_start,
	output logic signed [COORD_BITS-1:0] y_start,
	output logic signed [COORD_BITS-1:0] major_end,
	output logic signed [COORD_BITS+2:0] err_init,
	output logic [COORD_BITS-1:0]        abs_dx,
	output logic [COORD_BITS-1:0]        abs_dy
);
	import bres_pkg::*;

	localparam int MSB = COORD_BITS - 1;

	logic signed [COORD_BITS:0] dx;
	logic signed [COORD_BITS:0] dy;
	logic [COORD_BITS:0]        dx_mag;
	logic [COORD_BITS:0]        dy_mag;
	logic                       y_major;
	logic                       fwd;

	assign cmd.ready = !q_full;
	assign q_push    = cmd.valid && !q_full;

	assign dx = {cmd.x_end[MSB], cmd.x_end} - {cmd.x_begin[MSB], cmd.x_begin};
	assign dy = {cmd.y_end[MSB], cmd.y_end} - {cmd.y_begin[MSB], cmd.y_begin};

	assign dx_mag = dx[COORD_BITS] ? (COORD_BITS+1)'(-dx) : dx;
	assign dy_mag = dy[COORD_BITS] ? (COORD_BITS+1)'(-dy) : dy;
	assign abs_dx = dx_mag[MSB:0];
	assign abs_dy = dy_mag[MSB:0];

	assign y_major = abs_dy > abs_dx;
	// walk from the endpoint with the smaller major coordinate
	assign fwd     = y_major ? !dy[COORD_BITS] : !dx[COORD_BITS];

	always_comb begin
		if (y_major) begin
			err_init  = $signed({2'b00, abs_dx, 1'b0} - {3'b000, abs_dy});
			major_end = fwd ? cmd.y_end : cmd.y_begin;
		end else begin
			err_init  = $signed({2'b00, abs_dy, 1'b0} - {3'b000, abs_dx});
			major_end = fwd ? cmd.x_end : cmd.x_begin;
		end
		x_start = fwd ? cmd.x_begin : cmd.x_end;
		y_start = fwd ? cmd.y_begin : cmd.y_end;
	end

	always_comb begin
		ctl.load      = !cmd.kind;
		ctl.y_major   = y_major;
		ctl.minor_inc = (dx[COORD_BITS] && dy[COORD_BITS]) ||
			(!dx[COORD_BITS] && (dx != '0) && !dy[COORD_BITS] && (dy != '0));
		ctl.last      = (y_major ? y_start : x_start) >= major_end;
	end

endmodule

@@ design/bres_fifo.sv @@
// Short word queue between the decode front end and the stepping back end.
module bres_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	import bres_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	logic [WIDTH-1:0] mem [QUEUE_DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [PTR_W:0]   count_q;

	assign full  = count_q == (PTR_W+1)'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign rdata = mem[rptr_q];

	always_ff @(posedge clk) begin
		if (push) mem[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rptr_q + 1'b1;
			end
			count_q <= count_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
		end
	end

endmodule

@@ design/bres_back.sv @@
// Back end: steps the line state, clips each pixel and forms its address.
module bres_back #(
	parameter int COORD_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [bres_pkg::CFG_W-1:0]   screen_width,
	input  logic [bres_pkg::CFG_W-1:0]   screen_height,
	input  logic                         q_empty,
	output logic                         q_pop,
	input  bres_pkg::bres_ctl_t          ctl,
	input  logic signed [COORD_BITS-1:0] x_start,
	input  logic signed [COORD_BITS-1:0] y_start,
	input  logic signed [COORD_BITS-1:0] major_end,
	input  logic signed [COORD_BITS+2:0] err_init,
	input  logic [COORD_BITS-1:0]        abs_dx,
	input  logic [COORD_BITS-1:0]        abs_dy,
	bres_pix_if.source                   pixel
);
	import bres_pkg::*;

	localparam int MSB   = COORD_BITS - 1;
	localparam int ERR_W = COORD_BITS + 3;
	localparam int CW    = (COORD_BITS > CFG_W) ? COORD_BITS : CFG_W;

	// line state
	logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q, major_end_q;
	logic signed [ERR_W-1:0]      err_q;
	logic [COORD_BITS-1:0]        adx_q, ady_q;
	logic                         y_major_q, minor_inc_q, active_q;

	logic signed [COORD_BITS-1:0] nx, ny, minor_step;
	logic signed [ERR_W-1:0]      nerr, two_dx, two_dy;
	logic                         nlast;

	logic adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4;

	logic                         pv_s1, last_s1;
	logic signed [COORD_BITS-1:0] x_s1, y_s1;

	logic                         pv_s2, last_s2, on_s2;
	logic signed [COORD_BITS-1:0] x_s2, y_s2;
	logic [CFG_W-1:0]             row_s2, xlo_s2;

	logic                         pv_s3, last_s3, on_s3;
	logic signed [COORD_BITS-1:0] x_s3, y_s3;
	logic [2*CFG_W-1:0]           prod_s3;
	logic [CFG_W-1:0]             xlo_s3;

	logic                         pv_s4, last_s4, on_s4;
	logic signed [COORD_BITS-1:0] x_s4, y_s4;
	logic [ADDR_W-1:0]            addr_s4;

	logic [CW-1:0] xz, yz;
	logic          on_c;

	// the whole back pipeline moves when the output register can take a word
	assign adv   = !vld_s4 || pixel.ready;
	assign q_pop = adv && !q_empty;

	assign two_dx     = $signed({2'b00, adx_q, 1'b0});
	assign two_dy     = $signed({2'b00, ady_q, 1'b0});
	assign minor_step = minor_inc_q ? COORD_BITS'(1) : '1;

	always_comb begin
		nx   = cur_x_q;
		ny   = cur_y_q;
		nerr = err_q;
		if (!y_major_q) begin
			nx = cur_x_q + 1'b1;
			if (err_q[ERR_W-1]) begin
				nerr = err_q + two_dy;
			end else begin
				ny   = cur_y_q + minor_step;
				nerr = err_q + two_dy - two_dx;
			end
			nlast = nx >= major_end_q;
		end else begin
			ny = cur_y_q + 1'b1;
			if (err_q[ERR_W-1] || (err_q == '0)) begin
				nerr = err_q + two_dx;
			end else begin
				nx   = cur_x_q + minor_step;
				nerr = err_q + two_dx - two_dy;
			end
			nlast = ny >= major_end_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			major_end_q <= '0;
			err_q       <= '0;
			adx_q       <= '0;
			ady_q       <= '0;
			y_major_q   <= 1'b0;
			minor_inc_q <= 1'b0;
			active_q    <= 1'b0;
		end else if (q_pop) begin
			if (ctl.load) begin
				cur_x_q     <= x_start;
				cur_y_q     <= y_start;
				major_end_q <= major_end;
				err_q       <= err_init;
				adx_q       <= abs_dx;
				ady_q       <= abs_dy;
				y_major_q   <= ctl.y_major;
				minor_inc_q <= ctl.minor_inc;
				active_q    <= !ctl.last;
			end else if (active_q) begin
				cur_x_q  <= nx;
				cur_y_q  <= ny;
				err_q    <= nerr;
				active_q <= !nlast;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= !q_empty;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	assign xz   = CW'($unsigned(x_s1));
	assign yz   = CW'($unsigned(y_s1));
	assign on_c = pv_s1 && !x_s1[MSB] && !y_s1[MSB] &&
		(xz < CW'(screen_width)) && (yz < CW'(screen_height));

	always_ff @(posedge clk) begin
		if (adv) begin
			// stage 1: pixel of this word
			if (ctl.load) begin
				pv_s1   <= 1'b1;
				x_s1    <= x_start;
				y_s1    <= y_start;
				last_s1 <= ctl.last;
			end else if (active_q) begin
				pv_s1   <= 1'b1;
				x_s1    <= nx;
				y_s1    <= ny;
				last_s1 <= nlast;
			end else begin
				pv_s1   <= 1'b0;
				x_s1    <= '0;
				y_s1    <= '0;
				last_s1 <= 1'b0;
			end
			// stage 2: clip and flip the row
			pv_s2   <= pv_s1;
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			last_s2 <= last_s1;
			on_s2   <= on_c;
			row_s2  <= screen_height - CFG_W'(1) - yz[CFG_W-1:0];
			xlo_s2  <= xz[CFG_W-1:0];
			// stage 3: row times width
			pv_s3   <= pv_s2;
			x_s3    <= x_s2;
			y_s3    <= y_s2;
			last_s3 <= last_s2;
			on_s3   <= on_s2;
			prod_s3 <= row_s2 * screen_width;
			xlo_s3  <= xlo_s2;
			// stage 4: output register
			pv_s4   <= pv_s3;
			x_s4    <= x_s3;
			y_s4    <= y_s3;
			last_s4 <= last_s3;
			on_s4   <= on_s3;
			addr_s4 <= on_s3 ? ADDR_W'(prod_s3 + {{CFG_W{1'b0}}, xlo_s3}) : '0;
		end
	end

	assign pixel.valid       = vld_s4;
	assign pixel.pixel_valid = pv_s4;
	assign pixel.pixel_x     = x_s4;
	assign pixel.pixel_y     = y_s4;
	assign pixel.on_screen   = on_s4;
	assign pixel.pixel_addr  = addr_s4;
	assign pixel.last_pixel  = last_s4;

endmodule
